[hdl/spq_pkg.sv]
// shared types and constants for the stable priority queue
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int MAX_RESULTS  = 64;
  localparam int POS_W        = 6;

  typedef struct packed {
    logic [3:0]  prio;
    logic [15:0] reg_number;
    logic [7:0]  age;
    logic [31:0] phone;
  } rec_t;

  typedef enum logic [1:0] {
    ST_INSERTED   = 2'd0,
    ST_FULL       = 2'd1,
    ST_LIST_ENTRY = 2'd2,
    ST_LIST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_POS,
    S_LIST
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic rot;
    rec_t new_rec;
  } ctrl_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    rec_t             rec;
    logic             last;
  } rsp_t;

endpackage

[hdl/spq_if.sv]
// request and response channel interfaces
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  priority_req;
  logic [15:0] reg_number;
  logic [7:0]  age;
  logic [31:0] phone;

  modport source (output valid, mode, priority_req, reg_number, age, phone, input ready);
  modport sink   (input valid, mode, priority_req, reg_number, age, phone, output ready);
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  position;
  logic [3:0]  out_priority;
  logic [15:0] out_reg_number;
  logic [7:0]  out_age;
  logic [31:0] out_phone;
  logic        last;

  modport source (output valid, status, position, out_priority, out_reg_number, out_age,
                  out_phone, last, input ready);
  modport sink   (input valid, status, position, out_priority, out_reg_number, out_age,
                  out_phone, last, output ready);
endinterface

[hdl/stable_priority_queue.sv]
// top level: chain of record cells, list sequencer and response register
// insert: the chain updates on acceptance and the response is loaded from S_INS_POS; a full reject is loaded from idle
// list: one record per cycle from the head while the response register is free, loaded from S_LIST
// the chain rotates through all held records, so a list makes fill_count rotation steps
// one request is in flight at a time; a new one is taken once the response register is free
// synchronous reset empties the chain (valid bits and fill count cleared), records undefined
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CAPACITY-1:0] bound, bound_next;

  ctrl_t ctrl;
  logic  out_free, load_o, o_valid;
  rsp_t  o_data, o_next;

  logic [CAPACITY-1:0] c_valid, c_take, c_bound;
  rec_t                c_rec [CAPACITY];
  rec_t                new_rec;
  logic [POS_W-1:0]    pos_enc;

  assign new_rec = '{prio: req.priority_req, reg_number: req.reg_number,
                     age: req.age, phone: req.phone};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic pt, pv, nv;
    rec_t pr, nr;
    if (i == 0) begin : g_head
      assign pt = 1'b0;
      assign pv = 1'b0;
      assign pr = new_rec;
    end else begin : g_mid
      assign pt = c_take[i-1];
      assign pv = c_valid[i-1];
      assign pr = c_rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nv = 1'b0;
      assign nr = c_rec[0];
    end else begin : g_body
      assign nv = c_valid[i+1];
      assign nr = c_rec[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_take  (pt),
      .prev_valid (pv),
      .prev_rec   (pr),
      .next_valid (nv),
      .next_rec   (nr),
      .head_rec   (c_rec[0]),
      .valid      (c_valid[i]),
      .rec        (c_rec[i]),
      .take       (c_take[i]),
      .boundary   (c_bound[i])
    );
  end

  // slot index of the captured insert boundary, masked to the field width
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bound[i]) pos_enc = pos_enc | POS_W'(i);
    end
  end

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    idx_next        = idx;
    bound_next      = bound;
    ctrl            = '{ins: 1'b0, rot: 1'b0, new_rec: new_rec};
    load_o          = 1'b0;
    o_next          = '{status: ST_INSERTED, position: '0, rec: '0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          if (!req.mode) begin
            if (fill_count == CW'(CAPACITY)) begin
              load_o        = 1'b1;
              o_next.status = ST_FULL;
            end else begin
              ctrl.ins        = 1'b1;
              bound_next      = c_bound;
              fill_count_next = fill_count + 1'b1;
              state_next      = S_INS_POS;
            end
          end else if (fill_count == '0) begin
            load_o        = 1'b1;
            o_next.status = ST_LIST_EMPTY;
          end else begin
            idx_next   = '0;
            state_next = S_LIST;
          end
        end
      end
      S_INS_POS: begin
        load_o          = 1'b1;
        o_next.position = pos_enc;
        state_next      = S_IDLE;
      end
      S_LIST: begin
        if (out_free) begin
          ctrl.rot = 1'b1;
          idx_next = idx + 1'b1;
          // records past the result limit still rotate to restore the order
          if (32'(idx) < MAX_RESULTS) begin
            load_o          = 1'b1;
            o_next.status   = ST_LIST_ENTRY;
            o_next.position = POS_W'(idx);
            o_next.rec      = c_rec[0];
            o_next.last     = (32'(idx) + 1 == 32'(fill_count)) ||
                              (32'(idx) + 1 == MAX_RESULTS);
          end
          if (idx + 1'b1 == fill_count) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      if (load_o) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    bound <= bound_next;
    if (load_o) o_data <= o_next;
  end

  assign rsp.valid          = o_valid;
  assign rsp.status         = o_data.status;
  assign rsp.position       = o_data.position;
  assign rsp.out_priority   = o_data.rec.prio;
  assign rsp.out_reg_number = o_data.rec.reg_number;
  assign rsp.out_age        = o_data.rec.age;
  assign rsp.out_phone      = o_data.rec.phone;
  assign rsp.last           = o_data.last;

  a_fill_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(c_valid) == 32'(fill_count))
    else $error("held cells disagree with fill count");

  a_one_boundary: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_POS) |-> $onehot(bound))
    else $error("insert did not find exactly one slot");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (fill_count != '0))
    else $error("list walk on an empty chain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !rsp.ready) |-> !load_o)
    else $error("response register overwritten while stalled");

endmodule

[hdl/spq_cell.sv]
// one slot of the sorted chain: holds a record and shifts or rotates with its neighbors
module spq_cell
  import spq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctrl_t ctrl,
  input  logic  prev_take,
  input  logic  prev_valid,
  input  rec_t  prev_rec,
  input  logic  next_valid,
  input  rec_t  next_rec,
  input  rec_t  head_rec,
  output logic  valid,
  output rec_t  rec,
  output logic  take,
  output logic  boundary
);

  // new record goes at or before this slot
  assign take     = !valid || (rec.prio > ctrl.new_rec.prio);
  assign boundary = take && !prev_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins && take) begin
      valid <= prev_take ? prev_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && take) begin
      rec <= prev_take ? prev_rec : ctrl.new_rec;
    end else if (ctrl.rot && valid) begin
      // rotate toward the head, the last held slot wraps around to the head record
      rec <= next_valid ? next_rec : head_rec;
    end
  end

endmodule
